// ===== rtl/bpa_pkg.sv =====
// shared constants, types and helpers of the bitmap page allocator
`timescale 1ns / 1ps
package bpa_pkg;

   localparam int MAX_PAGES  = 256;
   localparam int PAGE_W     = 8;
   localparam int BIT_W      = 3;
   localparam int ROWS       = MAX_PAGES / 8;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COUNT_W    = 9;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int BYTES_W    = 6;
   localparam int RES_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [OP_W-1:0] OP_ALLOC      = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE_CHAIN = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT       = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_PAGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BITMAP_BYTES   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_PAGES = 1'd1;

   typedef struct packed {
      logic [BYTES_W-1:0] rows_used;
      logic [RES_W-1:0]   reserved;
      logic [COUNT_W-1:0] free_init;
   } cfg_type;

   typedef struct packed {
      logic             rd_en;
      logic [ROW_W-1:0] rd_row;
      logic             wr_en;
      logic [ROW_W-1:0] wr_row;
      logic [7:0]       wr_data;
   } map_req_type;

   typedef struct packed {
      logic              rd_en;
      logic [PAGE_W-1:0] rd_addr;
      logic              wr_en;
      logic [PAGE_W-1:0] wr_addr;
      logic [PAGE_W-1:0] wr_data;
   } link_req_type;

   // bitmap row as it stands straight after formatting
   function automatic logic [7:0] fmt_row(input logic [ROW_W-1:0] row,
                                          input logic [RES_W-1:0] res);
      logic [7:0]        r;
      logic [PAGE_W-1:0] pg;
      for (int i = 0; i < 8; i++) begin
         pg   = {row, BIT_W'(i)};
         r[i] = pg < PAGE_W'(res);
      end
      return r;
   endfunction

endpackage

// ===== rtl/bpa_req_if.sv =====
// request channel: operation and page
`timescale 1ns / 1ps
interface bpa_req_if import bpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [PAGE_W-1:0] page;

   modport source (output valid, operation, page, input ready);
   modport sink   (input valid, operation, page, output ready);
endinterface

// ===== rtl/bpa_rsp_if.sv =====
// response channel: page, status and counts
`timescale 1ns / 1ps
interface bpa_rsp_if import bpa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PAGE_W-1:0]   page_out;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  pages_freed;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, page_out, status, pages_freed, free_count, input ready);
   modport sink   (input valid, page_out, status, pages_freed, free_count, output ready);
endinterface

// ===== rtl/bpa_map_store.sv =====
// used-bitmap memory with per-row valid bits and row-full summary
`timescale 1ns / 1ps
module bpa_map_store import bpa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             format,
   input  cfg_type          cfg,
   input  map_req_type      req,
   output logic [7:0]       rd_data,
   output logic [ROWS-1:0]  row_full
);

   logic [7:0]       map_mem [ROWS];
   logic [7:0]       mem_q;
   logic [ROW_W-1:0] rd_row_ff;
   logic             rd_vld_ff;
   logic [ROWS-1:0]  vld_ff, vld_in;
   logic [ROWS-1:0]  full_ff, full_in;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         map_mem[req.wr_row] <= req.wr_data;
      end
      if (req.rd_en) begin
         mem_q     <= map_mem[req.rd_row];
         rd_row_ff <= req.rd_row;
         rd_vld_ff <= vld_ff[req.rd_row];
      end
   end

   always_comb begin
      vld_in  = vld_ff;
      full_in = full_ff;
      if (format) begin
         vld_in = '0;
      end else if (req.wr_en) begin
         vld_in[req.wr_row]  = 1'b1;
         full_in[req.wr_row] = (req.wr_data == 8'hff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      full_ff <= full_in;
   end

   // rows never written since formatting read as their formatted pattern
   assign rd_data = rd_vld_ff ? mem_q : fmt_row(rd_row_ff, cfg.reserved);

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         row_full[r] = vld_ff[r] ? full_ff[r]
                                 : (fmt_row(ROW_W'(r), cfg.reserved) == 8'hff);
      end
   end

endmodule

// ===== rtl/bpa_link_store.sv =====
// next-page link memory with per-entry valid bits
`timescale 1ns / 1ps
module bpa_link_store import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              format,
   input  link_req_type      req,
   output logic [PAGE_W-1:0] rd_data
);

   logic [PAGE_W-1:0]    link_mem [MAX_PAGES];
   logic [PAGE_W-1:0]    mem_q;
   logic                 rd_vld_ff;
   logic [MAX_PAGES-1:0] vld_ff, vld_in;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         link_mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         mem_q     <= link_mem[req.rd_addr];
         rd_vld_ff <= vld_ff[req.rd_addr];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (format) begin
         vld_in = '0;
      end else if (req.wr_en) begin
         vld_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rd_data = rd_vld_ff ? mem_q : '0;

endmodule

// ===== rtl/bpa_ctrl.sv =====
// operation sequencer: alloc, chain free, link lookup, free count and response word
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              format,
   input  cfg_type           cfg,
   bpa_req_if.sink           req_chan,
   bpa_rsp_if.source         rsp_chan,
   output map_req_type       map_req,
   input  logic [7:0]        map_rd_data,
   input  logic [ROWS-1:0]   row_full,
   output link_req_type      link_req,
   input  logic [PAGE_W-1:0] link_rd_data
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_AL_SCAN = 4'd1;
   localparam logic [3:0] S_AL_SET  = 4'd2;
   localparam logic [3:0] S_AL_LINK = 4'd3;
   localparam logic [3:0] S_CH_RD   = 4'd4;
   localparam logic [3:0] S_CH_WR   = 4'd5;
   localparam logic [3:0] S_NX_RD   = 4'd6;
   localparam logic [3:0] S_NX_DONE = 4'd7;
   localparam logic [3:0] S_RESP    = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [PAGE_W-1:0]   cur_ff, cur_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PAGE_W-1:0]   pg_out_ff, pg_out_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  freed_ff, freed_in;
   logic [COUNT_W-1:0]  free_total_ff, free_total_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_freed_ff, rsp_freed_in;
   logic [COUNT_W-1:0]  rsp_free_ff, rsp_free_in;

   logic [ROWS-1:0]     cand;
   logic [ROW_W-1:0]    cand_row;
   logic [BIT_W-1:0]    zero_bit;
   logic [7:0]          cur_mask;
   logic                rsp_free;

   assign req_chan.ready = (state_ff == S_IDLE) && !format;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // lowest row inside the configured span that still has a clear bit
   always_comb begin
      cand_row = '0;
      for (int r = 0; r < ROWS; r++) begin
         cand[r] = !row_full[r] && (BYTES_W'(r) < cfg.rows_used);
      end
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (cand[r]) begin
            cand_row = ROW_W'(r);
         end
      end
   end

   always_comb begin
      zero_bit = '0;
      for (int i = 7; i >= 0; i--) begin
         if (!map_rd_data[i]) begin
            zero_bit = BIT_W'(i);
         end
      end
   end

   assign cur_mask = 8'd1 << cur_ff[BIT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      row_in        = row_ff;
      pg_out_in     = pg_out_ff;
      status_in     = status_ff;
      freed_in      = freed_ff;
      free_total_in = free_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_free_in   = rsp_free_ff;
      map_req       = '0;
      link_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid && req_chan.ready) begin
               cur_in    = req_chan.page;
               pg_out_in = '0;
               status_in = ST_OK;
               freed_in  = '0;
               unique case (req_chan.operation)
                  OP_ALLOC: begin
                     state_in = S_AL_SCAN;
                  end
                  OP_FREE_CHAIN: begin
                     if (req_chan.page == '0) begin
                        status_in = ST_ZERO_PAGE;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_CH_RD;
                     end
                  end
                  OP_NEXT: begin
                     state_in = S_NX_RD;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_AL_SCAN: begin
            if (cand == '0) begin
               status_in = ST_NO_SPACE;
               state_in  = S_RESP;
            end else begin
               map_req.rd_en  = 1'b1;
               map_req.rd_row = cand_row;
               row_in         = cand_row;
               state_in       = S_AL_SET;
            end
         end
         S_AL_SET: begin
            map_req.wr_en    = 1'b1;
            map_req.wr_row   = row_ff;
            map_req.wr_data  = map_rd_data | (8'd1 << zero_bit);
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = {row_ff, zero_bit};
            link_req.wr_data = '0;
            pg_out_in        = {row_ff, zero_bit};
            if (free_total_ff != '0) begin
               free_total_in = free_total_ff - 1'b1;
            end
            state_in = (cur_ff != '0) ? S_AL_LINK : S_RESP;
         end
         S_AL_LINK: begin
            // predecessor link goes in after the new page's own link is cleared
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = cur_ff;
            link_req.wr_data = pg_out_ff;
            state_in         = S_RESP;
         end
         S_CH_RD: begin
            map_req.rd_en    = 1'b1;
            map_req.rd_row   = cur_ff[PAGE_W-1:BIT_W];
            link_req.rd_en   = 1'b1;
            link_req.rd_addr = cur_ff;
            state_in         = S_CH_WR;
         end
         S_CH_WR: begin
            if ((map_rd_data & cur_mask) != '0) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_row  = cur_ff[PAGE_W-1:BIT_W];
               map_req.wr_data = map_rd_data & ~cur_mask;
               free_total_in   = free_total_ff + 1'b1;
               freed_in        = freed_ff + 1'b1;
            end
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = cur_ff;
            link_req.wr_data = '0;
            // a cleared link ends the walk, which also breaks loops
            if (link_rd_data == '0) begin
               state_in = S_RESP;
            end else begin
               cur_in   = link_rd_data;
               state_in = S_CH_RD;
            end
         end
         S_NX_RD: begin
            link_req.rd_en   = 1'b1;
            link_req.rd_addr = cur_ff;
            state_in         = S_NX_DONE;
         end
         S_NX_DONE: begin
            pg_out_in = link_rd_data;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = pg_out_ff;
               rsp_status_in = status_ff;
               rsp_freed_in  = freed_ff;
               rsp_free_in   = free_total_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (format) begin
         free_total_in = cfg.free_init;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_total_ff <= free_total_in;
      end
      cur_ff        <= cur_in;
      row_ff        <= row_in;
      pg_out_ff     <= pg_out_in;
      status_ff     <= status_in;
      freed_ff      <= freed_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.page_out    = rsp_page_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.pages_freed = rsp_freed_ff;
   assign rsp_chan.free_count  = rsp_free_ff;

endmodule

// ===== rtl/bitmap_page_allocator_with_link_table.sv =====
// top level of the bitmap page allocator with next-page link table
`timescale 1ns / 1ps
// Page allocator over 256 pages: a 32 x 8 used-bitmap memory, a 256-entry
// next-page link memory and a free-page counter. One request at a time is
// processed; a finished response sits in an output register, so the next
// request is taken while it waits. An alloc passes the scan and set states,
// plus a link state when a predecessor link is written; a next lookup reads
// the link; a free_chain walk does a read-modify-write of one bitmap row and
// one link per page walked. The first free row is found from a per-row full
// summary. Writing either configuration register reformats the store: the
// cycle after the write is spent loading the free count and no request is
// taken then. Bitmap rows and links carry valid bits cleared at reset and on
// reformat, so there is no clearing pass over the memories.
module bitmap_page_allocator_with_link_table import bpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bpa_req_if.sink               req_chan,
   bpa_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [BYTES_W-1:0] bitmap_bytes_ff, bitmap_bytes_in;
   logic [RES_W-1:0]   reserved_ff, reserved_in;
   logic               fmt_pend_ff;

   logic [BYTES_W-1:0] rows_used;
   logic [COUNT_W-1:0] span;
   logic [RES_W-1:0]   res_raw;
   logic [RES_W-1:0]   res;
   cfg_type            cfg;

   map_req_type        map_req;
   link_req_type       link_req;
   logic [7:0]         map_rd_data;
   logic [ROWS-1:0]    row_full;
   logic [PAGE_W-1:0]  link_rd_data;

   always_comb begin
      bitmap_bytes_in = bitmap_bytes_ff;
      reserved_in     = reserved_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BITMAP_BYTES:   bitmap_bytes_in = csr_wdata[BYTES_W-1:0];
            CSR_RESERVED_PAGES: reserved_in     = csr_wdata[RES_W-1:0];
            default:            bitmap_bytes_in = bitmap_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitmap_bytes_ff <= BYTES_W'(32);
         reserved_ff     <= RES_W'(2);
         fmt_pend_ff     <= 1'b1;
      end else begin
         bitmap_bytes_ff <= bitmap_bytes_in;
         reserved_ff     <= reserved_in;
         fmt_pend_ff     <= csr_we;
      end
   end

   // span saturates at the map size; a reserved count of zero still keeps page 0
   assign rows_used = (bitmap_bytes_ff > BYTES_W'(ROWS)) ? BYTES_W'(ROWS) : bitmap_bytes_ff;
   assign span      = {rows_used, 3'b000};
   assign res_raw   = (reserved_ff == '0) ? RES_W'(1) : reserved_ff;
   assign res       = (COUNT_W'(res_raw) > span) ? span[RES_W-1:0] : res_raw;

   assign cfg.rows_used = rows_used;
   assign cfg.reserved  = res;
   assign cfg.free_init = span - COUNT_W'(res);

   bpa_map_store u_map (
      .clock    (clock),
      .reset    (reset),
      .format   (fmt_pend_ff),
      .cfg      (cfg),
      .req      (map_req),
      .rd_data  (map_rd_data),
      .row_full (row_full)
   );

   bpa_link_store u_link (
      .clock   (clock),
      .reset   (reset),
      .format  (fmt_pend_ff),
      .req     (link_req),
      .rd_data (link_rd_data)
   );

   bpa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .format       (fmt_pend_ff),
      .cfg          (cfg),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .map_req      (map_req),
      .map_rd_data  (map_rd_data),
      .row_full     (row_full),
      .link_req     (link_req),
      .link_rd_data (link_rd_data)
   );

endmodule
